// ----- hdl/lces_pkg.sv -----
// Shared widths, codes and types of the LED color effect sequencer.
`default_nettype none

package lces_pkg;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int HUE_W   = 9;
  localparam int ADDR_W  = 9;
  localparam int LVL_W   = 8;
  localparam int RAND_W  = 32;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 10;
  localparam int CFGI_W  = 3;
  localparam int CFGD_W  = 10;

  // Packed beat widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  // Modulus of the random color level
  localparam int LEVEL_MOD = 255;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // Effect kinds
  localparam logic [KIND_W-1:0] KIND_JUMP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FADE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RJUMP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RFADE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RCOLOR  = 3'd4;

  // Configuration register indexes
  localparam logic [CFGI_W-1:0] REG_KIND     = 3'd0;
  localparam logic [CFGI_W-1:0] REG_COUNT    = 3'd1;
  localparam logic [CFGI_W-1:0] REG_SAT      = 3'd2;
  localparam logic [CFGI_W-1:0] REG_INIT_LVL = 3'd3;
  localparam logic [CFGI_W-1:0] REG_MIN_LVL  = 3'd4;
  localparam logic [CFGI_W-1:0] REG_MAX_LVL  = 3'd5;

  // One result beat
  typedef struct packed {
    logic              fading_down;
    logic [LVL_W-1:0]  level;
    logic [LVL_W-1:0]  sat_out;
    logic [HUE_W-1:0]  hue;
  } lces_result_t;

endpackage

`default_nettype wire

// ----- hdl/lces_pal_mem.sv -----
// Hue palette memory: one write port, one registered read port.
`default_nettype none

module lces_pal_mem
  import lces_pkg::*;
#(
  parameter int DEPTH = 512
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic [HUE_W-1:0]          wr_data,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output      logic [HUE_W-1:0]          rd_data
);

  logic [HUE_W-1:0] mem [DEPTH];

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry, registered data in the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lces_mod_unit.sv -----
// Restoring remainder unit: 32-bit word modulo a narrow divisor, one bit a cycle.
`default_nettype none

module lces_mod_unit
  import lces_pkg::*;
#(
  parameter int DIV_W = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [RAND_W-1:0]  dividend,
  input  wire logic [DIV_W-1:0]   divisor,
  output      logic               done,
  output      logic [DIV_W-1:0]   remainder
);

  localparam int STEP_W = $clog2(RAND_W);

  logic [RAND_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  dsr_r;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, dvd_r[RAND_W-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    dvd_nxt = {dvd_r[RAND_W-2:0], 1'b0};
  end

  // Control: count the steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(RAND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- hdl/led_color_effect_sequencer_top.sv -----
// Top level of the LED color effect sequencer: control, effect state and beat ports.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in      | in  | in_tvalid/tready   | tuser mode, tdata address/hue/randoms
//  out     | out | out_tvalid/tready  | tdata hue, sat_out, level, fading_down
//  cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data (always ready)
//
// Palette writes, restarts and ignored modes complete on accept. A tick with a plain
// palette lookup passes the read state, the hue state and the output state (memory
// read, then result stage); a tick that needs a random pick first waits on the
// bit-serial remainder unit by the palette count, and random color folds its level
// word modulo 255 in the same span. One item is in work at a time; a stalled
// result holds in the output register until out_tready.
// Reset is synchronous; the palette holds no reset value.
`default_nettype none

module led_color_effect_sequencer_top
  import lces_pkg::*;
#(
  parameter int PALETTE_DEPTH = 512
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  // [81:50] random_second, [49:18] random_first, [17:9] entry_hue, [8:0] entry_address
  input  wire logic [IN_DATA_W-1:0]   in_tdata,
  // [1:0] mode
  input  wire logic [MODE_W-1:0]      in_tuser,
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  // [25] fading_down, [24:17] level, [16:9] sat_out, [8:0] hue
  output      logic [OUT_DATA_W-1:0]  out_tdata,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFGI_W-1:0]      cfg_index,
  input  wire logic [CFGD_W-1:0]      cfg_data
);

  localparam int IW  = (PALETTE_DEPTH > 2) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW0 = $clog2(PALETTE_DEPTH + 1);
  localparam int CW  = (CW0 > CNT_W) ? CW0 : CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_HUE  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Configuration registers
  logic [KIND_W-1:0] kind_r;
  logic [CNT_W-1:0]  count_r;
  logic [LVL_W-1:0]  sat_r;
  logic [LVL_W-1:0]  init_lvl_r;
  logic [LVL_W-1:0]  min_lvl_r;
  logic [LVL_W-1:0]  max_lvl_r;

  // Effect state
  logic [IW-1:0]     index_r;
  logic [HUE_W-1:0]  cur_hue_r;
  logic [LVL_W-1:0]  bright_r;
  logic              down_r;

  // Item work registers
  logic [2:0]        state_r;
  logic [IW-1:0]     rd_addr_r;
  logic [HUE_W-1:0]  shown_hue_r;
  logic [RAND_W-1:0] rand2_r;
  logic              out_valid_r;
  lces_result_t      out_data_r;

  // Input fields
  logic [ADDR_W-1:0] f_addr;
  logic [HUE_W-1:0]  f_hue;
  logic [RAND_W-1:0] f_rand1;
  logic [RAND_W-1:0] f_rand2;

  logic              accept;
  logic              tick;
  logic [CW-1:0]     count_ext;
  logic [CW-1:0]     eff_count;
  logic [CW-1:0]     next_index;
  logic [IW-1:0]     adv_index;
  logic              d1, d2;
  logic [LVL_W-1:0]  b1, b2;
  logic              at_min;
  logic              ramp_kind;
  logic              need_pick;
  logic              out_free;

  logic [9:0]        lvl_sum;
  logic [8:0]        lvl_fold;
  logic [LVL_W-1:0]  lvl_mod;

  logic              mod_start;
  logic [RAND_W-1:0] mod_dividend;
  logic [CW-1:0]     mod_divisor;
  logic              mod_done;
  logic [CW-1:0]     mod_rem;

  logic              wr_en;
  logic              rd_en;
  logic [HUE_W-1:0]  rd_data;

  assign f_addr  = in_tdata[8:0];
  assign f_hue   = in_tdata[17:9];
  assign f_rand1 = in_tdata[49:18];
  assign f_rand2 = in_tdata[81:50];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign tick      = accept && (in_tuser == MODE_TICK);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Clamp the palette count to 1..PALETTE_DEPTH
  always_comb begin
    count_ext = CW'(count_r);
    if (count_ext == '0) begin
      eff_count = CW'(1);
    end else if (count_ext > CW'(PALETTE_DEPTH)) begin
      eff_count = CW'(PALETTE_DEPTH);
    end else begin
      eff_count = count_ext;
    end
  end

  // Next palette index, wrapping at the effective count
  always_comb begin
    next_index = CW'(index_r) + CW'(1);
    adv_index  = (next_index >= eff_count) ? '0 : next_index[IW-1:0];
  end

  // One fade ramp step on the current level
  always_comb begin
    d1     = (bright_r == min_lvl_r) ? 1'b0 : down_r;
    b1     = d1 ? bright_r : bright_r + LVL_W'(1);
    d2     = (b1 == max_lvl_r) ? 1'b1 : d1;
    b2     = d2 ? b1 - LVL_W'(1) : b1;
    at_min = (b2 == min_lvl_r);
  end

  // Random color level: fold the word's bytes, then one conditional subtract
  always_comb begin
    lvl_sum  = 10'(rand2_r[7:0]) + 10'(rand2_r[15:8]) +
               10'(rand2_r[23:16]) + 10'(rand2_r[31:24]);
    lvl_fold = 9'(lvl_sum[7:0]) + 9'(lvl_sum[9:8]);
    lvl_mod  = (lvl_fold >= 9'(LEVEL_MOD)) ? LVL_W'(lvl_fold - 9'(LEVEL_MOD)) :
                                             lvl_fold[LVL_W-1:0];
  end

  assign ramp_kind = (kind_r == KIND_FADE) || (kind_r == KIND_RFADE);
  assign need_pick = (kind_r == KIND_RJUMP) || (kind_r == KIND_RCOLOR) ||
                     ((kind_r == KIND_RFADE) && at_min);

  // Remainder unit request: palette pick on accept
  assign mod_start    = tick && need_pick;
  assign mod_dividend = f_rand1;
  assign mod_divisor  = eff_count;

  // Palette port controls; accesses never overlap, so no forwarding
  assign wr_en = accept && (in_tuser == MODE_WRITE) &&
                 (CW'(f_addr) < CW'(PALETTE_DEPTH));
  assign rd_en = (state_r == S_RD);

  lces_pal_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IW'(f_addr)),
    .wr_data (f_hue),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  lces_mod_unit #(
    .DIV_W (CW)
  ) u_mod_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= KIND_JUMP;
      count_r    <= CNT_W'(1);
      sat_r      <= '1;
      init_lvl_r <= '1;
      min_lvl_r  <= '0;
      max_lvl_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KIND:     kind_r     <= cfg_data[KIND_W-1:0];
        REG_COUNT:    count_r    <= cfg_data[CNT_W-1:0];
        REG_SAT:      sat_r      <= cfg_data[LVL_W-1:0];
        REG_INIT_LVL: init_lvl_r <= cfg_data[LVL_W-1:0];
        REG_MIN_LVL:  min_lvl_r  <= cfg_data[LVL_W-1:0];
        REG_MAX_LVL:  max_lvl_r  <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: effect state update and item flow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      index_r   <= '0;
      cur_hue_r <= '0;
      bright_r  <= '1;
      down_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_tuser == MODE_RESTART)) begin
            bright_r <= init_lvl_r;
            down_r   <= 1'b0;
          end else if (tick) begin
            rd_addr_r   <= index_r;
            shown_hue_r <= cur_hue_r;
            rand2_r     <= f_rand2;
            // Apply the ramp and turn up at the minimum
            if (ramp_kind) begin
              bright_r <= b2;
              down_r   <= at_min ? 1'b0 : d2;
            end
            if ((kind_r == KIND_JUMP) || (kind_r == KIND_RJUMP) ||
                (ramp_kind && at_min)) begin
              index_r <= adv_index;
            end
            if (need_pick) begin
              state_r <= S_DIV;
            end else if ((kind_r == KIND_JUMP) || (kind_r == KIND_FADE)) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (mod_done) begin
            rd_addr_r <= IW'(mod_rem);
            if (kind_r == KIND_RCOLOR) begin
              bright_r <= lvl_mod;
            end
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_HUE;
        end
        S_HUE: begin
          // Random fade loads the hue for the next tick only
          cur_hue_r <= rd_data;
          if (kind_r != KIND_RFADE) begin
            shown_hue_r <= rd_data;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_data_r.hue         <= shown_hue_r;
      out_data_r.sat_out     <= sat_r;
      out_data_r.level       <= bright_r;
      out_data_r.fading_down <= down_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule

`default_nettype wire
